[sv/self_keying_add_cipher_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the self-keying add cipher unit
// Implication checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SELF_KEYING_ADD_CIPHER_UNIT_MACROS_SVH
`define SELF_KEYING_ADD_CIPHER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SAKC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define SAKC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SAKC_ASSERT_IMP(lbl, ante, cons, msg)
`define SAKC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[sv/sakc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sakc_pkg
// Shared widths, request codes and register indexes of the cipher unit.
// ----------------------------------------------------------------------------
package sakc_pkg;

	localparam int KEY_MAX    = 64;
	localparam int SLOT_W     = $clog2(KEY_MAX);
	localparam int LEN_W      = 7;
	localparam int BYTE_W     = 8;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [LEN_W-1:0]  len_t;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD    = 2'd0,
		OP_PROCESS = 2'd1,
		OP_START   = 2'd2
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 2'd1;

	// result and updated key byte of one process request
	typedef struct packed {
		byte_t result;
		byte_t new_key;
	} combine_t;

endpackage

[sv/sakc_combine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sakc_combine
// Adds or subtracts the key byte and folds the ciphertext back into the key.
// ----------------------------------------------------------------------------
module sakc_combine (
	input  logic             decrypt,
	input  sakc_pkg::byte_t  data,
	input  sakc_pkg::byte_t  key,
	output sakc_pkg::combine_t comb
);
	import sakc_pkg::*;

	byte_t sum;
	byte_t diff;
	byte_t cipher;

	always_comb begin
		sum    = data + key;
		diff   = data - key;
		// ciphertext is the output when encrypting, the input when decrypting
		cipher = decrypt ? data : sum;
		comb.result  = decrypt ? diff : sum;
		comb.new_key = key ^ cipher;
	end

endmodule

[sv/self_keying_add_cipher_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// self_keying_add_cipher_unit
// Byte stream cipher with a 64-byte key store that rewrites itself per byte.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// in        in_valid / in_ready    op, key_slot, byte_value
// out       out_valid / out_ready  result_byte
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request per cycle; a result is loaded at the edge where its request
// leaves the input stage, once the output register is free. The
// key store read is issued on accept and registered; the key write-back of the
// previous request is forwarded on an address match.
// Reset clears the pointer and registers; the key store is not cleared.
// A full output register stalls only process requests in the input stage.
// ----------------------------------------------------------------------------
`include "self_keying_add_cipher_unit_macros.svh"

module self_keying_add_cipher_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [sakc_pkg::OP_W-1:0]         op,
	input  logic [sakc_pkg::SLOT_W-1:0]       key_slot,
	input  logic [sakc_pkg::BYTE_W-1:0]       byte_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sakc_pkg::BYTE_W-1:0]       result_byte,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sakc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sakc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import sakc_pkg::*;

	byte_t    key_mem [KEY_MAX];

	len_t     key_length_q;
	logic     decrypt_q;
	slot_t    key_pointer_q;

	logic     s1_valid_q;
	op_t      op_s1;
	slot_t    slot_s1;
	slot_t    idx_s1;
	byte_t    data_s1;
	byte_t    key_rd_s1;
	logic     fwd_s1;
	byte_t    fwd_data_s1;

	logic     out_valid_q;
	byte_t    result_q;

	logic     in_fire;
	logic     s1_proc;
	logic     s1_adv;
	len_t     len_eff;
	len_t     ptr_inc;
	slot_t    ptr_next;
	byte_t    key_s1;
	combine_t comb;
	logic     wr_en;
	slot_t    wr_addr;
	byte_t    wr_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= len_t'(1);
			decrypt_q    <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_KEY_LENGTH:   key_length_q <= cfg_data[LEN_W-1:0];
				CFG_DECRYPT_MODE: decrypt_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage control
	always_comb begin
		s1_proc  = s1_valid_q && (op_s1 == OP_PROCESS);
		s1_adv   = s1_valid_q && (!s1_proc || !out_valid_q || out_ready);
		in_ready = !s1_valid_q || s1_adv;
		in_fire  = in_valid && in_ready;
	end

	// pointer advance, decided at accept
	always_comb begin
		len_eff = key_length_q;
		if (key_length_q == '0)
			len_eff = len_t'(1);
		else if (key_length_q > len_t'(KEY_MAX))
			len_eff = len_t'(KEY_MAX);
		ptr_inc  = {1'b0, key_pointer_q} + len_t'(1);
		ptr_next = (ptr_inc >= len_eff) ? '0 : ptr_inc[SLOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_pointer_q <= '0;
		end else if (in_fire) begin
			case (op)
				OP_LOAD, OP_START: key_pointer_q <= '0;
				OP_PROCESS:        key_pointer_q <= ptr_next;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (in_fire)
			s1_valid_q <= 1'b1;
		else if (s1_adv)
			s1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1       <= op_t'(op);
			slot_s1     <= key_slot;
			idx_s1      <= key_pointer_q;
			data_s1     <= byte_value;
			// the write-back landing this edge is not seen by the read
			fwd_s1      <= wr_en && (wr_addr == key_pointer_q);
			fwd_data_s1 <= wr_data;
		end
	end

	// key store: read on accept, write when the request leaves stage 1
	always_ff @(posedge clk) begin
		if (in_fire)
			key_rd_s1 <= key_mem[key_pointer_q];
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			key_mem[wr_addr] <= wr_data;
	end

	assign key_s1 = fwd_s1 ? fwd_data_s1 : key_rd_s1;

	sakc_combine u_combine (
		.decrypt (decrypt_q),
		.data    (data_s1),
		.key     (key_s1),
		.comb    (comb)
	);

	always_comb begin
		wr_en   = s1_adv && (op_s1 == OP_LOAD || op_s1 == OP_PROCESS);
		wr_addr = (op_s1 == OP_PROCESS) ? idx_s1 : slot_s1;
		wr_data = (op_s1 == OP_PROCESS) ? comb.new_key : data_s1;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_adv && s1_proc)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_proc)
			result_q <= comb.result;
	end

	assign out_valid   = out_valid_q;
	assign result_byte = result_q;

	`SAKC_ASSERT_NXT(a_load_rewinds, in_fire && op == OP_LOAD, key_pointer_q == '0, "load did not rewind pointer")
	`SAKC_ASSERT_NXT(a_proc_result, s1_adv && s1_proc, out_valid_q, "process request gave no result")
	`SAKC_ASSERT_IMP(a_fwd_owner, fwd_s1 && !in_fire, s1_valid_q || !$past(in_fire), "forward flag without request")
	`SAKC_ASSERT_IMP(a_empty_ready, !s1_valid_q, in_ready, "empty stage refused a request")

endmodule

[dv/self_keying_add_cipher_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// self_keying_add_cipher_unit_tb
// Drives load, process, start and unused requests through the cipher unit
// under random input gaps and output stalls. A local key image follows every
// accepted request, and each result byte is checked in order against it.
// ----------------------------------------------------------------------------
module self_keying_add_cipher_unit_tb;

	import sakc_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;
	localparam int              HOLD_CYCLES = 300;

	typedef struct {
		logic [OP_W-1:0] op;
		slot_t           slot;
		byte_t           value;
	} cipher_req_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [OP_W-1:0]       op = '0;
	slot_t                 key_slot = '0;
	byte_t                 byte_value = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	byte_t                 result_byte;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// request stream and expected cipher output
	cipher_req_t request_q[$];
	byte_t       cipher_out_q[$];
	cipher_req_t on_bus;

	// key image and settings as the block should hold them
	byte_t       key_img[KEY_MAX];
	int unsigned key_ptr;
	len_t        len_reg;
	logic        decrypt_reg;

	// stimulus-side view: which slots hold a key byte, and where the pointer is
	logic        key_loaded[KEY_MAX];
	int unsigned gen_ptr;
	int unsigned gen_len;

	logic        calm;
	logic        hold_kick;
	logic        rx_hold = 1'b0;
	int unsigned tx_gap;
	int unsigned rx_gap;
	int unsigned fail_cnt;
	byte_t       want;

	self_keying_add_cipher_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.key_slot    (key_slot),
		.byte_value  (byte_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_byte (result_byte),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned eff_len(len_t l);
		if (l == 0)
			return 1;
		if (l > KEY_MAX)
			return KEY_MAX;
		return 32'(l);
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int unsigned idle_len();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic apply_request(input cipher_req_t r);
		int unsigned idx;
		byte_t       k;
		byte_t       res;
		byte_t       ct;
		case (r.op)
			OP_LOAD: begin
				key_img[r.slot] = r.value;
				key_ptr = 0;
			end
			OP_START: key_ptr = 0;
			OP_PROCESS: begin
				idx = key_ptr;
				k = key_img[slot_t'(idx)];
				if (decrypt_reg) begin
					res = r.value - k;
					ct = r.value;
				end else begin
					res = r.value + k;
					ct = res;
				end
				key_img[slot_t'(idx)] = k ^ ct;
				key_ptr = (idx + 1 >= eff_len(len_reg)) ? 0 : idx + 1;
				cipher_out_q.push_back(res);
			end
			default: ;
		endcase
	endtask

	// never process on a slot that has not been loaded: load it instead
	task automatic queue_request(input logic [OP_W-1:0] o, input slot_t s, input byte_t v);
		cipher_req_t r;
		r.op = o;
		r.slot = s;
		r.value = v;
		if (o == OP_PROCESS && !key_loaded[slot_t'(gen_ptr)]) begin
			r.op = OP_LOAD;
			r.slot = slot_t'(gen_ptr);
		end
		case (r.op)
			OP_LOAD: begin
				key_loaded[r.slot] = 1'b1;
				gen_ptr = 0;
			end
			OP_START: gen_ptr = 0;
			OP_PROCESS: gen_ptr = (gen_ptr + 1 >= gen_len) ? 0 : gen_ptr + 1;
			default: ;
		endcase
		request_q.push_back(r);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_KEY_LENGTH) begin
			len_reg = data;
			gen_len = eff_len(data);
		end else if (idx == CFG_DECRYPT_MODE) begin
			decrypt_reg = data[0];
		end
		@(posedge clk);
	endtask

	task automatic set_mode(input len_t l, input logic dec);
		write_cfg(CFG_KEY_LENGTH, l);
		write_cfg(CFG_DECRYPT_MODE, {6'($urandom_range(0, 63)), dec});
	endtask

	// hold until every request is in and every result is out, then settle
	task automatic wait_idle();
		while (request_q.size() != 0 || in_valid || cipher_out_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap = 0;
		end else begin
			if (in_valid && in_ready)
				apply_request(on_bus);
			if (!in_valid || in_ready) begin
				if (tx_gap != 0 || request_q.size() == 0) begin
					if (tx_gap != 0)
						tx_gap--;
					in_valid <= 1'b0;
				end else begin
					on_bus = request_q.pop_front();
					in_valid <= 1'b1;
					op <= on_bus.op;
					key_slot <= on_bus.slot;
					byte_value <= on_bus.value;
					tx_gap = idle_len();
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_gap = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (cipher_out_q.size() == 0) begin
					$error("result_byte: no result expected, got %02h", result_byte);
					fail_cnt++;
				end else begin
					want = cipher_out_q.pop_front();
					if (result_byte !== want) begin
						$error("result_byte: expected %02h, actual %02h", want, result_byte);
						fail_cnt++;
					end
				end
			end
			if (rx_hold) begin
				out_ready <= 1'b0;
			end else if (rx_gap != 0) begin
				rx_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				rx_gap = idle_len();
			end
		end
	end

	// receiver hold-off, long enough to back the block up to its input
	initial begin
		wait (hold_kick);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int unsigned n;
		int unsigned cnt;
		len_t        l;
		for (int i = 0; i < KEY_MAX; i++) begin
			key_img[slot_t'(i)] = '0;
			key_loaded[slot_t'(i)] = 1'b0;
		end
		key_ptr = 0;
		len_reg = 1;
		decrypt_reg = 1'b0;
		gen_ptr = 0;
		gen_len = 1;
		calm = 1'b0;
		hold_kick = 1'b0;
		fail_cnt = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: length one, encrypt; extremes and the unused code
		queue_request(OP_LOAD, 6'd0, 8'hFF);
		queue_request(OP_PROCESS, 6'd0, 8'h00);
		queue_request(OP_PROCESS, 6'd63, 8'hFF);
		queue_request(OP_UNUSED, 6'd63, 8'hFF);
		queue_request(OP_PROCESS, 6'd0, 8'h01);
		queue_request(OP_START, 6'd63, 8'hFF);
		queue_request(OP_PROCESS, 6'd21, 8'h7F);
		queue_request(OP_LOAD, 6'd63, 8'h00);
		queue_request(OP_LOAD, 6'd1, 8'h5A);
		wait_idle();

		// length zero acts as one; decrypt
		set_mode(7'd0, 1'b1);
		queue_request(OP_PROCESS, 6'd0, 8'hFF);
		queue_request(OP_PROCESS, 6'd0, 8'h00);
		queue_request(OP_START, 6'd0, 8'h00);
		queue_request(OP_PROCESS, 6'd42, 8'h80);
		wait_idle();

		// length above the store saturates; load every slot, then wrap once
		set_mode(7'd127, 1'b0);
		for (int i = 0; i < KEY_MAX; i++)
			if (!key_loaded[slot_t'(i)])
				queue_request(OP_LOAD, slot_t'(i), byte_t'($urandom_range(0, 255)));
		queue_request(OP_START, 6'd0, 8'h00);
		for (int i = 0; i < 70; i++)
			queue_request(OP_PROCESS, 6'd0, byte_t'($urandom_range(0, 255)));
		wait_idle();

		// pointer now past a shortened length: use it, then wrap
		set_mode(7'd3, 1'b1);
		queue_request(OP_PROCESS, 6'd0, 8'hC3);
		queue_request(OP_PROCESS, 6'd0, 8'h3C);
		queue_request(OP_UNUSED, 6'd0, 8'h00);
		queue_request(OP_PROCESS, 6'd0, 8'h55);
		wait_idle();

		for (int p = 0; p < 12; p++) begin
			case (p)
				0: l = 7'd1;
				1: l = 7'd64;
				2: l = 7'd0;
				3: l = 7'd127;
				default: l = len_t'($urandom_range(0, 127));
			endcase
			set_mode(l, p[0]);
			calm = ($urandom_range(0, 3) == 0);
			if (p == 4) begin
				// sender keeps offering while the receiver holds off
				calm = 1'b1;
				hold_kick = 1'b1;
				queue_request(OP_START, slot_t'($urandom_range(0, 63)), 8'h00);
				for (int i = 0; i < 90; i++)
					queue_request(OP_PROCESS, 6'd0, byte_t'($urandom_range(0, 255)));
			end
			cnt = 0;
			while (cnt < 50) begin
				if ($urandom_range(0, 9) < 7) begin
					n = $urandom_range(0, 2);
					for (int i = 0; i < n; i++)
						queue_request(OP_LOAD, slot_t'($urandom_range(0, 63)),
							byte_t'($urandom_range(0, 255)));
					queue_request(OP_START, slot_t'($urandom_range(0, 63)),
						byte_t'($urandom_range(0, 255)));
					n = $urandom_range(1, 40);
					for (int i = 0; i < n; i++)
						queue_request(OP_PROCESS, slot_t'($urandom_range(0, 63)),
							byte_t'($urandom_range(0, 255)));
					cnt += n + 1;
				end else begin
					n = $urandom_range(1, 6);
					for (int i = 0; i < n; i++)
						queue_request(OP_W'($urandom_range(0, 3)),
							slot_t'($urandom_range(0, 63)), byte_t'($urandom_range(0, 255)));
					cnt += n;
				end
			end
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (fail_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[files.f]
+incdir+sv
sv/sakc_pkg.sv
sv/sakc_combine.sv
sv/self_keying_add_cipher_unit.sv
dv/self_keying_add_cipher_unit_tb.sv
